>>> rtl/ritoa_pkg.sv
package ritoa_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int IN_BITS        = 32;
	localparam int FMT_BITS       = 3;
	localparam int CHAR_BITS      = 7;

	localparam logic [FMT_BITS-1:0] FMT_DEC    = 3'd0;
	localparam logic [FMT_BITS-1:0] FMT_BIN    = 3'd1;
	localparam logic [FMT_BITS-1:0] FMT_BIN_UP = 3'd2;
	localparam logic [FMT_BITS-1:0] FMT_OCT    = 3'd3;
	localparam logic [FMT_BITS-1:0] FMT_HEX    = 3'd4;
	localparam logic [FMT_BITS-1:0] FMT_HEX_UP = 3'd5;

	typedef enum logic [1:0] {
		RAD_DEC,
		RAD_BIN,
		RAD_OCT,
		RAD_HEX
	} radix_t;

	localparam logic [CHAR_BITS-1:0] CH_ZERO = 7'h30;
	localparam logic [CHAR_BITS-1:0] CH_NINE = 7'h39;
	localparam logic [CHAR_BITS-1:0] CH_UA   = 7'h41;
	localparam logic [CHAR_BITS-1:0] CH_UB   = 7'h42;
	localparam logic [CHAR_BITS-1:0] CH_UF   = 7'h46;
	localparam logic [CHAR_BITS-1:0] CH_UX   = 7'h58;
	localparam logic [CHAR_BITS-1:0] CH_LA   = 7'h61;
	localparam logic [CHAR_BITS-1:0] CH_LB   = 7'h62;
	localparam logic [CHAR_BITS-1:0] CH_LF   = 7'h66;
	localparam logic [CHAR_BITS-1:0] CH_LX   = 7'h78;

	function automatic int imax(int a, int b);
		return (a > b) ? a : b;
	endfunction

	// decimal digits needed for the largest value of the given width (elaboration only)
	function automatic int dec_digits(int bits);
		longint unsigned m;
		int n;
		m = (64'd1 << bits) - 64'd1;
		n = 0;
		for (int i = 0; i < 20; i++) begin
			if (m != 0) begin
				m = m / 10;
				n++;
			end
		end
		return (n == 0) ? 1 : n;
	endfunction

	function automatic logic [CHAR_BITS-1:0] digit_char(logic [3:0] d, logic upper);
		if (d >= 4'd10)
			return (upper ? CH_UA : CH_LA) + {3'b000, d - 4'd10};
		return CH_ZERO + {3'b000, d};
	endfunction

endpackage

>>> rtl/radix_integer_to_ascii.sv
// channel | signals                      | word
// --------+------------------------------+--------------------------------------------
// in      | s_tvalid s_tready s_tdata    | s_tdata[31:0] value, s_tuser[2:0] format
//         | s_tuser                      |
// out     | m_tvalid m_tready m_tdata    | m_tdata[6:0] character, m_tlast last
//         | m_tlast                      |
//
// One value is in flight at a time; s_tready is high only while idle.
// Decimal: shift-add-3 conversion, then a leading-zero skip whose last step hands over, then
// the characters, one per cycle while the output register is free. Other radixes go straight
// from the accept to the leading-zero skip.
// Characters leave through one output register; a stall there holds the sequencer.
// Reset clears the sequencer and the output valid; nothing else needs clearing.
module radix_integer_to_ascii #(
	parameter int VALUE_BITS = ritoa_pkg::VALUE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [2:0] s_tuser,   // [2:0] format
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] character, [7] zero
	output logic       m_tlast    // last
);

	localparam int VB = (VALUE_BITS < ritoa_pkg::IN_BITS) ? VALUE_BITS : ritoa_pkg::IN_BITS;
	localparam int ND = ritoa_pkg::dec_digits(VB);
	localparam int NO = (VB + 2) / 3;
	localparam int NH = (VB + 3) / 4;
	localparam int DW = ritoa_pkg::imax(ritoa_pkg::imax(VB, 3 * NO),
		ritoa_pkg::imax(4 * NH, 4 * ND));
	localparam int CW = $clog2(ritoa_pkg::imax(VB, ND) + 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CONV  = 6'b000010,
		ST_SKIP  = 6'b000100,
		ST_PRE0  = 6'b001000,
		ST_PRE1  = 6'b010000,
		ST_DIGIT = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [DW-1:0] dr_q, dr_d;      // digit register, first digit left aligned
	logic [VB-1:0] bin_q, bin_d;    // binary feed for the decimal conversion
	ritoa_pkg::radix_t radix_q, radix_in;
	logic upper_q, upper_in;
	logic pre_q, tag_q, tag_in, pre_in;
	logic [ritoa_pkg::CHAR_BITS-1:0] char_q, emit_char;
	logic last_q, emit_last, emit;
	logic m_tvalid_q;
	logic out_free, accept;
	logic [VB-1:0] val;
	logic [3:0] dig;
	logic [DW-1:0] dr_shift, adj, dab;

	assign val      = s_tdata[VB-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

	always_comb begin
		radix_in = ritoa_pkg::RAD_DEC;
		upper_in = 1'b0;
		tag_in   = 1'b0;
		unique case (s_tuser) inside
			ritoa_pkg::FMT_BIN, ritoa_pkg::FMT_BIN_UP: begin
				radix_in = ritoa_pkg::RAD_BIN;
				tag_in   = 1'b1;
			end
			ritoa_pkg::FMT_OCT: radix_in = ritoa_pkg::RAD_OCT;
			ritoa_pkg::FMT_HEX, ritoa_pkg::FMT_HEX_UP: begin
				radix_in = ritoa_pkg::RAD_HEX;
				tag_in   = 1'b1;
			end
			default: radix_in = ritoa_pkg::RAD_DEC;
		endcase
		upper_in = (s_tuser == ritoa_pkg::FMT_BIN_UP) || (s_tuser == ritoa_pkg::FMT_HEX_UP);
		// octal gets its lone '0' prefix only for non-zero values
		pre_in   = tag_in || ((radix_in == ritoa_pkg::RAD_OCT) && (|val));
	end

	always_comb begin
		case (radix_q)
			ritoa_pkg::RAD_BIN: begin
				dig      = {3'b000, dr_q[DW-1]};
				dr_shift = dr_q << 1;
			end
			ritoa_pkg::RAD_OCT: begin
				dig      = {1'b0, dr_q[DW-1 -: 3]};
				dr_shift = dr_q << 3;
			end
			default: begin
				dig      = dr_q[DW-1 -: 4];
				dr_shift = dr_q << 4;
			end
		endcase
	end

	// shift-add-3 step; BCD digits sit in the top 4*ND bits
	always_comb begin
		adj = dr_q;
		for (int i = 0; i < ND; i++) begin
			if (adj[DW-1-4*i -: 4] >= 4'd5)
				adj[DW-1-4*i -: 4] = adj[DW-1-4*i -: 4] + 4'd3;
		end
		dab = adj << 1;
		dab[DW-4*ND] = bin_q[VB-1];
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		dr_d      = dr_q;
		bin_d     = bin_q;
		emit      = 1'b0;
		emit_char = ritoa_pkg::CH_ZERO;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (radix_in)
						ritoa_pkg::RAD_BIN: begin
							dr_d    = DW'(val) << (DW - VB);
							cnt_d   = CW'(VB);
							state_d = ST_SKIP;
						end
						ritoa_pkg::RAD_OCT: begin
							dr_d    = DW'(val) << (DW - 3 * NO);
							cnt_d   = CW'(NO);
							state_d = ST_SKIP;
						end
						ritoa_pkg::RAD_HEX: begin
							dr_d    = DW'(val) << (DW - 4 * NH);
							cnt_d   = CW'(NH);
							state_d = ST_SKIP;
						end
						default: begin
							dr_d    = '0;
							bin_d   = val;
							cnt_d   = CW'(VB);
							state_d = ST_CONV;
						end
					endcase
				end
			end
			ST_CONV: begin
				dr_d  = dab;
				bin_d = bin_q << 1;
				cnt_d = cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					cnt_d   = CW'(ND);
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zero digits, keep at least one
				if (dig == 4'd0 && cnt_q > CW'(1)) begin
					dr_d  = dr_shift;
					cnt_d = cnt_q - CW'(1);
				end else begin
					state_d = pre_q ? ST_PRE0 : ST_DIGIT;
				end
			end
			ST_PRE0: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = ritoa_pkg::CH_ZERO;
					state_d   = tag_q ? ST_PRE1 : ST_DIGIT;
				end
			end
			ST_PRE1: begin
				if (out_free) begin
					emit = 1'b1;
					if (radix_q == ritoa_pkg::RAD_BIN)
						emit_char = upper_q ? ritoa_pkg::CH_UB : ritoa_pkg::CH_LB;
					else
						emit_char = upper_q ? ritoa_pkg::CH_UX : ritoa_pkg::CH_LX;
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = ritoa_pkg::digit_char(dig, upper_q);
					emit_last = (cnt_q == CW'(1));
					dr_d      = dr_shift;
					cnt_d     = cnt_q - CW'(1);
					if (cnt_q == CW'(1))
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		dr_q  <= dr_d;
		bin_q <= bin_d;
		if (accept) begin
			radix_q <= radix_in;
			upper_q <= upper_in;
			tag_q   <= tag_in;
			pre_q   <= pre_in;
		end
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	// one value at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input accepted while a value is in flight");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT || state_q == ST_SKIP) |-> cnt_q != '0)
		else $error("digit counter ran out");

	// the final character is always a digit, never a prefix
	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |->
			((m_tdata[6:0] >= ritoa_pkg::CH_ZERO && m_tdata[6:0] <= ritoa_pkg::CH_NINE) ||
			(m_tdata[6:0] >= ritoa_pkg::CH_LA && m_tdata[6:0] <= ritoa_pkg::CH_LF) ||
			(m_tdata[6:0] >= ritoa_pkg::CH_UA && m_tdata[6:0] <= ritoa_pkg::CH_UF)))
		else $error("last word is not a digit");

endmodule
